>>> hdl/otbde_pkg.sv
package otbde_pkg;

    localparam int SLOT_BITS   = 12;
    localparam int ORDER_SLOTS = 2 ** SLOT_BITS;
    localparam int PROBE_LIMIT = 8;
    localparam int PCNT_W      = $clog2(PROBE_LIMIT + 1);

    // home slot = bits [32 +: SLOT_BITS] of ref * HASH_MUL
    localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam int HASH_W = 32 + SLOT_BITS;
    localparam int HLO    = HASH_W / 2;
    localparam int HHI    = HASH_W - HLO;

    localparam logic REG_BOOK_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_EXEC       = 3'd1,
        OP_EXEC_PRICE = 3'd2,
        OP_CANCEL     = 3'd3,
        OP_DELETE     = 3'd4,
        OP_REPLACE    = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_DELTA     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_DISABLED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DECIDE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [63:0] ref_key;
        logic [63:0] symbol;
        logic [31:0] price;
        logic [31:0] remaining;
        logic        side;
    } t_entry;

    typedef struct packed {
        logic [2:0]  status;
        logic        delta_add;
        logic [63:0] symbol;
        logic        side_sell;
        logic [31:0] level_price;
        logic [31:0] level_qty;
        logic        trade_valid;
        logic [31:0] trade_price;
        logic [31:0] trade_shares;
        logic        last;
    } t_result;

endpackage

>>> hdl/otbde_hash.sv
module otbde_hash (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [63:0]                    i_key,
    output logic                           o_done,
    output logic [otbde_pkg::SLOT_BITS-1:0] o_home
);

    localparam logic [otbde_pkg::HLO-1:0] K_LO = otbde_pkg::HASH_MUL[otbde_pkg::HLO-1:0];
    localparam logic [otbde_pkg::HHI-1:0] K_HI =
        otbde_pkg::HASH_MUL[otbde_pkg::HASH_W-1:otbde_pkg::HLO];

    logic [otbde_pkg::HLO-1:0]    r_a;
    logic [otbde_pkg::HHI-1:0]    r_b;
    logic [2:0]                   r_v;
    logic                         r_done;
    logic [2*otbde_pkg::HLO-1:0]  r_p0;
    logic [otbde_pkg::HHI-1:0]    r_p1;
    logic [otbde_pkg::HHI-1:0]    r_p2;

    logic [otbde_pkg::HASH_W-1:0] w_ahi;
    logic [otbde_pkg::HASH_W-1:0] w_blo;
    logic [otbde_pkg::HHI-1:0]    w_mid;
    logic [otbde_pkg::HASH_W-1:0] w_sum;

    // one partial product per cycle
    assign w_ahi = r_a * K_HI;
    assign w_blo = r_b * K_LO;
    assign w_mid = r_p1 + r_p2;
    assign w_sum = otbde_pkg::HASH_W'(r_p0) + {w_mid, {otbde_pkg::HLO{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_start};
            r_done <= r_v[2];
        end
        if (i_start) begin
            r_a <= i_key[otbde_pkg::HLO-1:0];
            r_b <= i_key[otbde_pkg::HASH_W-1:otbde_pkg::HLO];
        end
        if (r_v[0]) r_p0 <= r_a * K_LO;
        if (r_v[1]) r_p1 <= w_ahi[otbde_pkg::HHI-1:0];
        if (r_v[2]) r_p2 <= w_blo[otbde_pkg::HHI-1:0];
    end

    assign o_done = r_done;
    assign o_home = w_sum[otbde_pkg::HASH_W-1:32];

endmodule

>>> hdl/otbde_table.sv
module otbde_table (
    input  logic                            i_clk,
    input  logic                            i_rd_en,
    input  logic [otbde_pkg::SLOT_BITS-1:0] i_rd_addr,
    output otbde_pkg::t_entry               o_rd_data,
    input  logic                            i_wr_en,
    input  logic [otbde_pkg::SLOT_BITS-1:0] i_wr_addr,
    input  otbde_pkg::t_entry               i_wr_data
);

    otbde_pkg::t_entry r_mem [otbde_pkg::ORDER_SLOTS];
    otbde_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

>>> hdl/order_tracking_book_delta_engine.sv
// Channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------------
// message   | i_in_valid / o_in_stall    | i_opcode .. i_subscribed
// delta     | o_out_valid / i_out_stall  | o_status .. o_last
// config    | psel penable pwrite pready | paddr pwdata prdata
//
// One message at a time. Lookup: the hash (one partial product a cycle), then
// pipelined reads over the PROBE_LIMIT slots of the probe window, then a
// read-modify-write in S_DECIDE and the load of the output register in S_EMIT;
// replace adds a second lookup, of the new reference, when the old one is found.
// Disabled or ignored beats skip the lookup. After reset a clearing pass over
// all ORDER_SLOTS slots zeroes the table; o_in_stall is high throughout. A stalled
// output holds; the next message can be taken while the last result still waits.
module order_tracking_book_delta_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_order_ref,
    input  logic [63:0] i_new_order_ref,
    input  logic [63:0] i_symbol_key,
    input  logic        i_side_sell,
    input  logic [31:0] i_price,
    input  logic [31:0] i_shares,
    input  logic        i_printable,
    input  logic [31:0] i_exec_price,
    input  logic        i_subscribed,
    // deltas out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_delta_add,
    output logic [63:0] o_out_symbol,
    output logic        o_out_side_sell,
    output logic [31:0] o_level_price,
    output logic [31:0] o_level_qty,
    output logic        o_trade_valid,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_shares,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [otbde_pkg::SLOT_BITS-1:0] LAST_SLOT = '1;

    otbde_pkg::t_state  r_state, n_state;
    logic               r_enable;

    // latched message
    logic [2:0]         r_op;
    logic [63:0]        r_new_ref;
    logic [63:0]        r_sym;
    logic               r_side;
    logic [31:0]        r_price;
    logic [31:0]        r_shares;
    logic               r_printable;
    logic [31:0]        r_xprice;

    logic [63:0]        r_key;
    logic               r_pass;        // second lookup of a replace
    logic [63:0]        r_old_sym;
    logic               r_old_side;

    // probe window scan
    logic [otbde_pkg::SLOT_BITS-1:0] r_addr;
    logic [otbde_pkg::PCNT_W-1:0]    r_iss;
    logic                            r_pend;
    logic [otbde_pkg::SLOT_BITS-1:0] r_pend_idx;
    logic                            r_hit;
    logic [otbde_pkg::SLOT_BITS-1:0] r_hit_idx;
    otbde_pkg::t_entry               r_hit_e;
    logic                            r_free_ok;
    logic [otbde_pkg::SLOT_BITS-1:0] r_free_idx;

    logic [otbde_pkg::SLOT_BITS-1:0] r_clr_idx;

    otbde_pkg::t_result r_res;
    logic               r_more;
    otbde_pkg::t_result r_out;
    logic               r_ov;

    // combinational
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_early;
    otbde_pkg::t_result w_early_res;
    logic               w_hash_start;
    logic [63:0]        w_hash_key;
    logic               w_hash_done;
    logic [otbde_pkg::SLOT_BITS-1:0] w_home;
    logic               w_rd_en;
    otbde_pkg::t_entry  w_rd_data;
    logic               w_wr_en;
    logic [otbde_pkg::SLOT_BITS-1:0] w_wr_addr;
    otbde_pkg::t_entry  w_wr_data;
    otbde_pkg::t_result w_dec_res;
    logic               w_dec_more;
    logic [31:0]        w_new_rem;
    logic               w_cfg_wr;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_new_rem  = (r_hit_e.remaining > r_shares) ? r_hit_e.remaining - r_shares : '0;

    otbde_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_hash_key),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    otbde_table u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // messages that need no lookup
    always_comb begin
        w_early_res      = '0;
        w_early_res.last = 1'b1;
        w_early          = 1'b1;
        if (!r_enable) begin
            w_early_res.status = otbde_pkg::ST_DISABLED;
        end else if (i_opcode > otbde_pkg::OP_REPLACE) begin
            w_early_res.status = otbde_pkg::ST_IGNORED;
        end else if (i_opcode == otbde_pkg::OP_ADD && !i_subscribed) begin
            w_early_res.status = otbde_pkg::ST_IGNORED;
        end else begin
            w_early = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            otbde_pkg::S_CLEAR:  if (r_clr_idx == LAST_SLOT) n_state = otbde_pkg::S_IDLE;
            otbde_pkg::S_IDLE: begin
                if (w_in_acc) n_state = w_early ? otbde_pkg::S_EMIT : otbde_pkg::S_HASH;
            end
            otbde_pkg::S_HASH:   if (w_hash_done) n_state = otbde_pkg::S_PROBE;
            otbde_pkg::S_PROBE: begin
                if (r_iss == otbde_pkg::PCNT_W'(otbde_pkg::PROBE_LIMIT) && !r_pend)
                    n_state = otbde_pkg::S_DECIDE;
            end
            otbde_pkg::S_DECIDE: n_state = otbde_pkg::S_EMIT;
            otbde_pkg::S_EMIT: begin
                if (w_out_free) n_state = r_more ? otbde_pkg::S_HASH : otbde_pkg::S_IDLE;
            end
            default:             n_state = otbde_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer: hash start, table access, decision
    always_comb begin
        o_in_stall   = (r_state != otbde_pkg::S_IDLE);
        w_hash_start = 1'b0;
        w_hash_key   = i_order_ref;
        if (r_state == otbde_pkg::S_IDLE && w_in_acc && !w_early) begin
            w_hash_start = 1'b1;
        end else if (r_state == otbde_pkg::S_EMIT && w_out_free && r_more) begin
            w_hash_start = 1'b1;
            w_hash_key   = r_new_ref;
        end

        w_rd_en = (r_state == otbde_pkg::S_PROBE) &&
                  (r_iss != otbde_pkg::PCNT_W'(otbde_pkg::PROBE_LIMIT));

        w_wr_en    = 1'b0;
        w_wr_addr  = r_clr_idx;
        w_wr_data  = '0;
        w_dec_res  = '0;
        w_dec_more = 1'b0;
        w_dec_res.last = 1'b1;

        if (r_state == otbde_pkg::S_CLEAR) begin
            w_wr_en = 1'b1;
        end else if (r_state == otbde_pkg::S_DECIDE) begin
            if (r_pass || r_op == otbde_pkg::OP_ADD) begin
                // insertion: live match first, else first free slot
                if (r_hit || r_free_ok) begin
                    w_wr_en                = 1'b1;
                    w_wr_addr              = r_hit ? r_hit_idx : r_free_idx;
                    w_wr_data.valid        = 1'b1;
                    w_wr_data.ref_key      = r_key;
                    w_wr_data.symbol       = r_pass ? r_old_sym : r_sym;
                    w_wr_data.side         = r_pass ? r_old_side : r_side;
                    w_wr_data.price        = r_price;
                    w_wr_data.remaining    = r_shares;
                    w_dec_res.status       = otbde_pkg::ST_DELTA;
                    w_dec_res.delta_add    = 1'b1;
                    w_dec_res.symbol       = w_wr_data.symbol;
                    w_dec_res.side_sell    = w_wr_data.side;
                    w_dec_res.level_price  = r_price;
                    w_dec_res.level_qty    = r_shares;
                end else begin
                    w_dec_res.status = otbde_pkg::ST_FULL;
                end
            end else if (!r_hit) begin
                w_dec_res.status = otbde_pkg::ST_NOT_FOUND;
            end else begin
                w_wr_en               = 1'b1;
                w_wr_addr             = r_hit_idx;
                w_wr_data             = r_hit_e;
                w_dec_res.status      = otbde_pkg::ST_DELTA;
                w_dec_res.symbol      = r_hit_e.symbol;
                w_dec_res.side_sell   = r_hit_e.side;
                w_dec_res.level_price = r_hit_e.price;
                w_dec_res.level_qty   = r_shares;
                case (r_op)
                    otbde_pkg::OP_EXEC, otbde_pkg::OP_EXEC_PRICE: begin
                        w_dec_res.trade_valid  = 1'b1;
                        w_dec_res.trade_price  =
                            (r_op == otbde_pkg::OP_EXEC_PRICE && r_printable) ?
                            r_xprice : r_hit_e.price;
                        w_dec_res.trade_shares = r_shares;
                        w_wr_data.remaining    = w_new_rem;
                        w_wr_data.valid        = (w_new_rem != '0);
                    end
                    otbde_pkg::OP_CANCEL: begin
                        // kept even at zero shares
                        w_wr_data.remaining = w_new_rem;
                    end
                    otbde_pkg::OP_DELETE: begin
                        w_dec_res.level_qty = r_hit_e.remaining;
                        w_wr_data.valid     = 1'b0;
                    end
                    otbde_pkg::OP_REPLACE: begin
                        w_dec_res.level_qty = r_hit_e.remaining;
                        w_dec_res.last      = 1'b0;
                        w_wr_data.valid     = 1'b0;
                        w_dec_more          = 1'b1;
                    end
                    default: begin
                        w_wr_en   = 1'b0;
                        w_dec_res = '0;
                        w_dec_res.status = otbde_pkg::ST_IGNORED;
                        w_dec_res.last   = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= otbde_pkg::S_CLEAR;
            r_clr_idx <= '0;
            r_enable  <= 1'b1;
            r_ov      <= 1'b0;
            r_more    <= 1'b0;
            r_pass    <= 1'b0;
            r_pend    <= 1'b0;
            r_iss     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == otbde_pkg::S_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (w_cfg_wr && paddr[2] == otbde_pkg::REG_BOOK_ENABLE) r_enable <= pwdata[0];

            if (r_state == otbde_pkg::S_EMIT && w_out_free) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall)                  r_ov <= 1'b0;

            if (r_state == otbde_pkg::S_IDLE && w_in_acc) begin
                r_more <= 1'b0;
                r_pass <= 1'b0;
            end else if (r_state == otbde_pkg::S_DECIDE) begin
                r_more <= w_dec_more;
            end else if (r_state == otbde_pkg::S_EMIT && w_out_free && r_more) begin
                r_more <= 1'b0;
                r_pass <= 1'b1;
            end

            if (r_state == otbde_pkg::S_HASH) begin
                r_iss  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == otbde_pkg::S_PROBE) begin
                if (w_rd_en) r_iss <= r_iss + 1'b1;
                r_pend <= w_rd_en;
            end
        end

        // payload
        if (r_state == otbde_pkg::S_IDLE && w_in_acc) begin
            r_op        <= i_opcode;
            r_new_ref   <= i_new_order_ref;
            r_sym       <= i_symbol_key;
            r_side      <= i_side_sell;
            r_price     <= i_price;
            r_shares    <= i_shares;
            r_printable <= i_printable;
            r_xprice    <= i_exec_price;
            r_res       <= w_early_res;
        end
        if (w_hash_start) r_key <= w_hash_key;

        if (r_state == otbde_pkg::S_HASH) begin
            r_addr    <= w_home;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_state == otbde_pkg::S_PROBE) begin
            if (w_rd_en) r_addr <= r_addr + 1'b1;   // wraps at the table end
            r_pend_idx <= r_addr;
            if (r_pend) begin
                if (w_rd_data.valid && w_rd_data.ref_key == r_key && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_pend_idx;
                    r_hit_e   <= w_rd_data;
                end
                if (!w_rd_data.valid && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_pend_idx;
                end
            end
        end

        if (r_state == otbde_pkg::S_DECIDE) begin
            r_res      <= w_dec_res;
            r_old_sym  <= r_hit_e.symbol;
            r_old_side <= r_hit_e.side;
        end
        if (r_state == otbde_pkg::S_EMIT && w_out_free) r_out <= r_res;
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_out.status;
    assign o_delta_add     = r_out.delta_add;
    assign o_out_symbol    = r_out.symbol;
    assign o_out_side_sell = r_out.side_sell;
    assign o_level_price   = r_out.level_price;
    assign o_level_qty     = r_out.level_qty;
    assign o_trade_valid   = r_out.trade_valid;
    assign o_trade_price   = r_out.trade_price;
    assign o_trade_shares  = r_out.trade_shares;
    assign o_last          = r_out.last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == otbde_pkg::REG_BOOK_ENABLE) ? {31'd0, r_enable} : 32'd0;

`ifndef SYNTH
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.status != otbde_pkg::ST_DELTA |->
            r_out.level_qty == '0 && r_out.symbol == '0 && !r_out.trade_valid)
        else $error("non-delta result carries payload");

    a_trade_decrease: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.trade_valid |-> r_out.status == otbde_pkg::ST_DELTA && !r_out.delta_add)
        else $error("trade on a non-decreasing delta");

    a_wr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> r_state == otbde_pkg::S_CLEAR || r_state == otbde_pkg::S_DECIDE)
        else $error("table write outside clear or decide");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_out.last |-> r_more || r_state == otbde_pkg::S_HASH ||
            r_state == otbde_pkg::S_PROBE || r_state == otbde_pkg::S_DECIDE ||
            r_state == otbde_pkg::S_EMIT)
        else $error("non-final result with no follow-up pending");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == otbde_pkg::S_DECIDE |->
            $past(r_iss) == otbde_pkg::PCNT_W'(otbde_pkg::PROBE_LIMIT))
        else $error("decision before full window scan");
`endif

endmodule

>>> tb/sv/order_tracking_book_delta_engine_test.sv
module order_tracking_book_delta_engine_test;

    // opcodes the block must treat as ignored
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [2:0] ADDR_BOOK_ENABLE = {otbde_pkg::REG_BOOK_ENABLE, 2'b00};
    localparam int RANDOM_BEATS = 1100;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 60;   // beyond worst lookup time, replace included

    typedef struct {
        logic [2:0]  opcode;
        logic [63:0] order_ref;
        logic [63:0] new_ref;
        logic [63:0] symbol;
        logic        side_sell;
        logic [31:0] price;
        logic [31:0] shares;
        logic        printable;
        logic [31:0] exec_price;
        logic        subscribed;
    } t_msg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_opcode = '0;
    logic [63:0] i_order_ref = '0;
    logic [63:0] i_new_order_ref = '0;
    logic [63:0] i_symbol_key = '0;
    logic        i_side_sell = 1'b0;
    logic [31:0] i_price = '0;
    logic [31:0] i_shares = '0;
    logic        i_printable = 1'b0;
    logic [31:0] i_exec_price = '0;
    logic        i_subscribed = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_delta_add;
    logic [63:0] o_out_symbol;
    logic        o_out_side_sell;
    logic [31:0] o_level_price;
    logic [31:0] o_level_qty;
    logic        o_trade_valid;
    logic [31:0] o_trade_price;
    logic [31:0] o_trade_shares;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    order_tracking_book_delta_engine dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Book model: shadow order table plus the enable register
    // ---------------------------------------------------------------------
    bit          book_live [otbde_pkg::ORDER_SLOTS];
    logic [63:0] book_ref  [otbde_pkg::ORDER_SLOTS];
    logic [63:0] book_sym  [otbde_pkg::ORDER_SLOTS];
    logic [31:0] book_px   [otbde_pkg::ORDER_SLOTS];
    logic [31:0] book_rem  [otbde_pkg::ORDER_SLOTS];
    logic        book_side [otbde_pkg::ORDER_SLOTS];
    logic        enable_shadow = 1'b1;

    otbde_pkg::t_result expected_deltas[$];
    int          errors = 0;
    int          beats_sent = 0;
    int          deltas_seen = 0;
    int          status_seen [8];
    int          cycles = 0;
    logic [63:0] cluster_refs[$];   // references sharing one home slot

    function automatic int home_of(logic [63:0] r);
        logic [63:0] prod;
        prod = r * otbde_pkg::HASH_MUL;
        return int'(prod[32 +: otbde_pkg::SLOT_BITS]);
    endfunction

    function automatic int locate(logic [63:0] r);
        int i;
        i = home_of(r);
        for (int p = 0; p < otbde_pkg::PROBE_LIMIT; p++) begin
            if (book_live[i] && book_ref[i] == r) return i;
            i = (i + 1) % otbde_pkg::ORDER_SLOTS;
        end
        return -1;
    endfunction

    function automatic bit book_insert(logic [63:0] r, logic [63:0] sym, logic side,
                                       logic [31:0] px, logic [31:0] qty);
        int s;
        int i;
        s = locate(r);
        if (s < 0) begin
            i = home_of(r);
            for (int p = 0; p < otbde_pkg::PROBE_LIMIT && s < 0; p++) begin
                if (!book_live[i]) s = i;
                i = (i + 1) % otbde_pkg::ORDER_SLOTS;
            end
        end
        if (s < 0) return 1'b0;
        book_live[s] = 1'b1;
        book_ref[s]  = r;
        book_sym[s]  = sym;
        book_px[s]   = px;
        book_rem[s]  = qty;
        book_side[s] = side;
        return 1'b1;
    endfunction

    function automatic otbde_pkg::t_result status_only(otbde_pkg::t_status st, logic lst);
        otbde_pkg::t_result d;
        d = '0;
        d.status = st;
        d.last = lst;
        return d;
    endfunction

    function automatic otbde_pkg::t_result level_delta(logic up, logic [63:0] sym,
                                                       logic side, logic [31:0] px,
                                                       logic [31:0] qty, logic lst);
        otbde_pkg::t_result d;
        d = '0;
        d.status = otbde_pkg::ST_DELTA;
        d.delta_add = up;
        d.symbol = sym;
        d.side_sell = side;
        d.level_price = px;
        d.level_qty = qty;
        d.last = lst;
        return d;
    endfunction

    // Works out the deltas of one accepted beat and queues them.
    function automatic void book_update(t_msg m);
        int s;
        otbde_pkg::t_result d;
        logic [31:0] rem;
        logic [63:0] osym;
        logic oside;
        if (!enable_shadow) begin
            expected_deltas.push_back(status_only(otbde_pkg::ST_DISABLED, 1'b1));
            return;
        end
        if (m.opcode > otbde_pkg::OP_REPLACE) begin
            expected_deltas.push_back(status_only(otbde_pkg::ST_IGNORED, 1'b1));
            return;
        end
        if (m.opcode == otbde_pkg::OP_ADD) begin
            if (!m.subscribed)
                expected_deltas.push_back(status_only(otbde_pkg::ST_IGNORED, 1'b1));
            else if (!book_insert(m.order_ref, m.symbol, m.side_sell, m.price, m.shares))
                expected_deltas.push_back(status_only(otbde_pkg::ST_FULL, 1'b1));
            else
                expected_deltas.push_back(level_delta(1'b1, m.symbol, m.side_sell,
                                                      m.price, m.shares, 1'b1));
            return;
        end
        s = locate(m.order_ref);
        if (s < 0) begin
            expected_deltas.push_back(status_only(otbde_pkg::ST_NOT_FOUND, 1'b1));
            return;
        end
        rem = book_rem[s];
        case (m.opcode)
            otbde_pkg::OP_EXEC, otbde_pkg::OP_EXEC_PRICE: begin
                d = level_delta(1'b0, book_sym[s], book_side[s], book_px[s], m.shares, 1'b1);
                d.trade_valid = 1'b1;
                d.trade_price = (m.opcode == otbde_pkg::OP_EXEC_PRICE && m.printable) ?
                                m.exec_price : book_px[s];
                d.trade_shares = m.shares;
                expected_deltas.push_back(d);
                book_rem[s] = (rem > m.shares) ? rem - m.shares : '0;
                if (book_rem[s] == '0) book_live[s] = 1'b0;
            end
            otbde_pkg::OP_CANCEL: begin
                expected_deltas.push_back(level_delta(1'b0, book_sym[s], book_side[s],
                                                      book_px[s], m.shares, 1'b1));
                book_rem[s] = (rem > m.shares) ? rem - m.shares : '0;
            end
            otbde_pkg::OP_DELETE: begin
                expected_deltas.push_back(level_delta(1'b0, book_sym[s], book_side[s],
                                                      book_px[s], rem, 1'b1));
                book_live[s] = 1'b0;
            end
            default: begin
                osym = book_sym[s];
                oside = book_side[s];
                expected_deltas.push_back(level_delta(1'b0, osym, oside, book_px[s],
                                                      rem, 1'b0));
                book_live[s] = 1'b0;
                if (!book_insert(m.new_ref, osym, oside, m.price, m.shares))
                    expected_deltas.push_back(status_only(otbde_pkg::ST_FULL, 1'b1));
                else
                    expected_deltas.push_back(level_delta(1'b1, osym, oside, m.price,
                                                          m.shares, 1'b1));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Delta checker
    // ---------------------------------------------------------------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH delta %0d %s: got %h want %h", deltas_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin
        otbde_pkg::t_result w;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_deltas.size() == 0) begin
                report("unexpected beat, status", o_status, 0);
            end else begin
                w = expected_deltas.pop_front();
                status_seen[w.status]++;
                if (o_status != w.status)             report("status", o_status, w.status);
                if (o_delta_add != w.delta_add)       report("delta_add", o_delta_add, w.delta_add);
                if (o_out_symbol != w.symbol)         report("symbol", o_out_symbol, w.symbol);
                if (o_out_side_sell != w.side_sell)   report("side", o_out_side_sell, w.side_sell);
                if (o_level_price != w.level_price)   report("level_price", o_level_price,
                                                             w.level_price);
                if (o_level_qty != w.level_qty)       report("level_qty", o_level_qty, w.level_qty);
                if (o_trade_valid != w.trade_valid)   report("trade_valid", o_trade_valid,
                                                             w.trade_valid);
                if (o_trade_price != w.trade_price)   report("trade_price", o_trade_price,
                                                             w.trade_price);
                if (o_trade_shares != w.trade_shares) report("trade_shares", o_trade_shares,
                                                             w.trade_shares);
                if (o_last != w.last)                 report("last", o_last, w.last);
            end
            deltas_seen++;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver stall: the pattern is redrawn at random among four; a hold request forces
    // a long solid stall so the engine backs up into its input
    // ---------------------------------------------------------------------
    int hold_request = 0;
    int hold_left = 0;
    int stall_mode = 0;

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= cycles[2];
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sender: beats go in bursts, a random gap between bursts
    // ---------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_beat(t_msg m);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_opcode        <= m.opcode;
        i_order_ref     <= m.order_ref;
        i_new_order_ref <= m.new_ref;
        i_symbol_key    <= m.symbol;
        i_side_sell     <= m.side_sell;
        i_price         <= m.price;
        i_shares        <= m.shares;
        i_printable     <= m.printable;
        i_exec_price    <= m.exec_price;
        i_subscribed    <= m.subscribed;
        do @(posedge i_clk); while (o_in_stall);
        book_update(m);
        beats_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_deltas.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_enable(logic val);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_BOOK_ENABLE; pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        enable_shadow = val;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Beat builders
    // ---------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    function automatic t_msg noise_msg(logic [2:0] op);
        t_msg m;
        m.opcode = op;
        m.order_ref = rand64();
        m.new_ref = rand64();
        m.symbol = rand64();
        m.side_sell = $urandom;
        m.price = $urandom;
        m.shares = rand_qty();
        m.printable = $urandom;
        m.exec_price = $urandom;
        m.subscribed = 1'b1;
        return m;
    endfunction

    function automatic t_msg order_msg(logic [2:0] op, logic [63:0] r, logic [31:0] qty);
        t_msg m;
        m = noise_msg(op);
        m.order_ref = r;
        m.shares = qty;
        return m;
    endfunction

    // random live reference, or a fresh one when the book is empty
    function automatic logic [63:0] live_ref();
        int i;
        i = $urandom_range(0, otbde_pkg::ORDER_SLOTS - 1);
        for (int n = 0; n < otbde_pkg::ORDER_SLOTS; n++) begin
            if (book_live[i]) return book_ref[i];
            i = (i + 1) % otbde_pkg::ORDER_SLOTS;
        end
        return rand64();
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_basic_orders();
        t_msg m;
        logic [63:0] r;
        m = order_msg(otbde_pkg::OP_ADD, '0, '1);
        m.symbol = '1; m.side_sell = 1'b1; m.price = '1;
        send_beat(m);
        m = order_msg(otbde_pkg::OP_ADD, '1, 32'd100);
        m.symbol = '0; m.side_sell = 1'b0; m.price = '0;
        send_beat(m);
        m.subscribed = 1'b0;                        // unsubscribed add
        send_beat(m);
        send_beat(noise_msg(OP_SPARE_LO));
        send_beat(noise_msg(OP_SPARE_HI));
        send_beat(order_msg(otbde_pkg::OP_EXEC, '1, 32'd40));  // partial fill
        m = order_msg(otbde_pkg::OP_EXEC_PRICE, '1, 32'd10);
        m.printable = 1'b1;
        send_beat(m);
        m.printable = 1'b0;
        send_beat(m);
        send_beat(order_msg(otbde_pkg::OP_EXEC, '1, 32'd500)); // overfill: saturates, frees
        send_beat(order_msg(otbde_pkg::OP_EXEC, '1, 32'd1));   // now unknown
        send_beat(order_msg(otbde_pkg::OP_CANCEL, '0, '1));    // cancel to zero keeps it
        send_beat(order_msg(otbde_pkg::OP_CANCEL, '0, 32'd7));
        send_beat(order_msg(otbde_pkg::OP_DELETE, '0, '0));
        send_beat(order_msg(otbde_pkg::OP_DELETE, '0, '0));
        r = rand64();
        send_beat(order_msg(otbde_pkg::OP_ADD, r, 32'd300));
        send_beat(order_msg(otbde_pkg::OP_ADD, r, 32'd55));    // live reference overwritten
        m = order_msg(otbde_pkg::OP_REPLACE, r, 32'd77);
        m.new_ref = rand64();
        send_beat(m);
        send_beat(order_msg(otbde_pkg::OP_DELETE, m.new_ref, '0));
        send_beat(order_msg(otbde_pkg::OP_REPLACE, rand64(), 32'd3));
        send_beat(order_msg(otbde_pkg::OP_CANCEL, rand64(), 32'd3));
        drain();
    endtask

    // fill one probe window, then overflow it by add and by replace
    task automatic test_full_window();
        t_msg m;
        logic [63:0] r;
        int target;
        target = 200;
        while (cluster_refs.size() < otbde_pkg::PROBE_LIMIT + 4) begin
            r = rand64();
            if (home_of(r) == target) cluster_refs.push_back(r);
        end
        for (int k = 0; k <= otbde_pkg::PROBE_LIMIT; k++)
            send_beat(order_msg(otbde_pkg::OP_ADD, cluster_refs[k], 32'd10 + k));
        r = rand64();
        send_beat(order_msg(otbde_pkg::OP_ADD, r, 32'd20));
        m = order_msg(otbde_pkg::OP_REPLACE, r, 32'd21);
        m.new_ref = cluster_refs[otbde_pkg::PROBE_LIMIT + 1];
        send_beat(m);
        send_beat(order_msg(otbde_pkg::OP_DELETE, r, '0));     // gone after failed replace
        m = order_msg(otbde_pkg::OP_REPLACE, cluster_refs[2], 32'd22);
        m.new_ref = cluster_refs[otbde_pkg::PROBE_LIMIT + 2];  // freed slot is reused
        send_beat(m);
        drain();
    endtask

    task automatic test_disabled_book();
        write_enable(1'b0);
        for (int op = 0; op < 8; op++) send_beat(order_msg(3'(op), live_ref(), 32'd5));
        write_enable(1'b1);
        send_beat(order_msg(otbde_pkg::OP_DELETE, live_ref(), '0));
        drain();
    endtask

    function automatic t_msg random_msg();
        t_msg m;
        int pick;
        logic [63:0] r;
        pick = $urandom_range(0, 99);
        r = live_ref();
        m = order_msg(otbde_pkg::OP_EXEC, r, rand_qty());
        if (pick < 30) begin
            m.opcode = otbde_pkg::OP_ADD;
            case ($urandom_range(0, 9))
                0, 1:    m.order_ref = r;
                2:       m.order_ref = cluster_refs[$urandom_range(0, cluster_refs.size() - 1)];
                default: m.order_ref = rand64();
            endcase
            m.subscribed = ($urandom_range(0, 19) != 0);
        end else if (pick < 45) begin
            m.opcode = $urandom_range(0, 1) ? otbde_pkg::OP_EXEC : otbde_pkg::OP_EXEC_PRICE;
        end else if (pick < 58) begin
            m.opcode = otbde_pkg::OP_CANCEL;
        end else if (pick < 70) begin
            m.opcode = otbde_pkg::OP_DELETE;
        end else if (pick < 85) begin
            m.opcode = otbde_pkg::OP_REPLACE;
            m.new_ref = ($urandom_range(0, 7) == 0) ?
                        cluster_refs[$urandom_range(0, cluster_refs.size() - 1)] : rand64();
        end else if (pick < 95) begin
            m.opcode = 3'($urandom_range(1, 5));
            m.order_ref = rand64();                 // most likely unknown
        end else begin
            m.opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        end
        return m;
    endfunction

    task automatic test_random_traffic(int count);
        for (int k = 0; k < count; k++) begin
            if (k == count / 3) write_enable(1'b0);
            if (k == count / 3 + 15) write_enable(1'b1);
            send_beat(random_msg());
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_back_pressure();
        hold_request = 400;
        for (int k = 0; k < 40; k++) send_beat(random_msg());
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_orders();
        test_full_window();
        test_disabled_book();
        test_back_pressure();
        test_random_traffic(RANDOM_BEATS);
        test_back_pressure();
        if (expected_deltas.size() != 0) begin
            errors++;
            $display("%0d deltas never arrived", expected_deltas.size());
        end
        $display("covered %0d beats, %0d deltas: %0d level, %0d unknown, %0d full,",
                 beats_sent, deltas_seen, status_seen[otbde_pkg::ST_DELTA],
                 status_seen[otbde_pkg::ST_NOT_FOUND], status_seen[otbde_pkg::ST_FULL]);
        $display("  %0d ignored, %0d disabled, with bursts, stalls and long hold-offs",
                 status_seen[otbde_pkg::ST_IGNORED], status_seen[otbde_pkg::ST_DISABLED]);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/otbde_pkg.sv
hdl/otbde_hash.sv
hdl/otbde_table.sv
hdl/order_tracking_book_delta_engine.sv
tb/sv/order_tracking_book_delta_engine_test.sv
